/* rtl/psufd_pkg.sv */
// Package for the power supply status fault deglitcher.
// Holds field widths, fault indexes, PMBus bit positions and register codes.
// No dependencies.
package psufd_pkg;

	localparam int SW_W       = 16;
	localparam int MFR_W      = 8;
	localparam int MV_W       = 19;
	localparam int CNT_W      = 3;
	localparam int FAIL_W     = 8;
	localparam int NUM_FAULTS = 13;
	localparam int CLS_W      = 2;

	localparam int IN_TDATA_W  = 48;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TDATA_W = 24;
	localparam int APB_AW      = 4;
	localparam int APB_DW      = 32;

	// fault_flags bit order
	localparam int F_CML     = 0;
	localparam int F_INPUT   = 1;
	localparam int F_VOUT_OV = 2;
	localparam int F_IOUT_OC = 3;
	localparam int F_VOUT_UV = 4;
	localparam int F_FAN     = 5;
	localparam int F_TEMP    = 6;
	localparam int F_PGOOD   = 7;
	localparam int F_MFR     = 8;
	localparam int F_VIN_UV  = 9;
	localparam int F_KILL    = 10;
	localparam int F_12VCS   = 11;
	localparam int F_CS12V   = 12;

	// STATUS_WORD bit positions
	localparam int SWB_CML       = 1;
	localparam int SWB_TEMP      = 2;
	localparam int SWB_VIN_UV    = 3;
	localparam int SWB_IOUT_OC   = 4;
	localparam int SWB_VOUT_OV   = 5;
	localparam int SWB_UNIT_OFF  = 6;
	localparam int SWB_FANS      = 10;
	localparam int SWB_PGOOD_NEG = 11;
	localparam int SWB_MFR       = 12;
	localparam int SWB_INPUT     = 13;
	localparam int SWB_VOUT      = 15;

	// vendor status byte bit positions
	localparam int MFRB_KILL  = 4;
	localparam int MFRB_12VCS = 6;
	localparam int MFRB_CS12V = 7;

	// voltage classes
	localparam logic [CLS_W-1:0] CLS_NONE = 2'd0;
	localparam logic [CLS_W-1:0] CLS_LOW  = 2'd1;
	localparam logic [CLS_W-1:0] CLS_HIGH = 2'd2;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_MFR_DECODE = 2'd0;
	localparam logic [1:0] REG_VIN_MIN    = 2'd1;
	localparam logic [1:0] REG_VIN_LOW    = 2'd2;

	localparam logic [MV_W-1:0] VIN_MIN_RST = 19'd20000;
	localparam logic [MV_W-1:0] VIN_LOW_RST = 19'd160000;

	typedef struct packed {
		logic                  present;
		logic                  status_read_ok;
		logic [SW_W-1:0]       sts_word;
		logic [MFR_W-1:0]      vendor_sts;
		logic                  vin_read_ok;
		logic [MV_W-1:0]       vin_millivolts;
	} poll_t;

	typedef struct packed {
		logic                  vin_uv_clear_request;
		logic                  read_fail_report;
		logic [CLS_W-1:0]      voltage_class;
		logic                  available;
		logic [NUM_FAULTS-1:0] fault_flags;
	} result_t;

endpackage

/* rtl/psu_status_fault_deglitcher.sv */
// Fault deglitcher for one polled PMBus power supply: top level.
// Depends on psufd_pkg.
//
// Usage:
//  s_axis carries one poll per request: tuser holds the flags, tdata the
//  readings. m_axis returns one result per poll. The APB port sets the
//  vendor decode enable and the two input voltage thresholds; write it
//  only while no poll is in flight.
//  A poll accepted on s_axis is held in the input register; its result is
//  then registered in the output register that drives m_axis. Throughput:
//  one poll per cycle while m_axis is not stalled. The per-fault counters, the
//  fail count and the presence/class history sit in one register bank
//  that is updated as a poll moves from the input register to the output
//  register, so each poll sees the state its predecessor left.
//  Reset clears the counters, fail count and history, empties both
//  pipeline stages, and loads the register reset values.
//  When m_axis_tready is low the result holds in the output register; the
//  input register still takes one more poll, then s_axis_tready drops
//  until the output is taken.
module psu_status_fault_deglitcher #(
	parameter int FAULT_LIMIT    = 3,
	parameter int PGOOD_LIMIT    = 5,
	parameter int READ_LOG_LIMIT = 3
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// APB configuration
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [psufd_pkg::APB_AW-1:0]          paddr,
	input  logic [psufd_pkg::APB_DW-1:0]          pwdata,
	output logic [psufd_pkg::APB_DW-1:0]          prdata,
	output logic                                  pready,
	// poll stream
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// [15:0] sts_word, [23:16] vendor_sts, [42:24] vin_millivolts, rest zero
	input  logic [psufd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// [0] present, [1] status_read_ok, [2] vin_read_ok
	input  logic [psufd_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
	// result stream
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// [12:0] fault_flags, [13] available, [15:14] voltage_class,
	// [16] read_fail_report, [17] vin_uv_clear_request, rest zero
	output logic [psufd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

	localparam int CW = psufd_pkg::CNT_W;
	localparam int NF = psufd_pkg::NUM_FAULTS;
	localparam int FW = psufd_pkg::FAIL_W;
	localparam logic [CW-1:0] LIM_FAULT = CW'(FAULT_LIMIT);
	localparam logic [CW-1:0] LIM_PGOOD = CW'(PGOOD_LIMIT);
	localparam logic [FW-1:0] LIM_LOG   = FW'(READ_LOG_LIMIT);
	localparam logic [FW-1:0] FAIL_SAT  = {FW{1'b1}};

	// configuration
	logic                          mfr_decode_enable_q;
	logic [psufd_pkg::MV_W-1:0]    vin_min_mv_q;
	logic [psufd_pkg::MV_W-1:0]    vin_low_line_mv_q;
	logic                          cfg_wr;

	// pipeline
	logic                          valid_s1;
	psufd_pkg::poll_t              poll_s1;
	logic                          valid_s2;
	psufd_pkg::result_t            res_s2;
	logic                          advance;
	logic                          take_in;

	// state
	logic [NF-1:0][CW-1:0]         cnt_q;
	logic [FW-1:0]                 fail_q;
	logic                          last_present_q;
	logic [psufd_pkg::CLS_W-1:0]   last_cls_q;

	// next state
	logic [NF-1:0][CW-1:0]         cnt_base;
	logic [NF-1:0][CW-1:0]         cnt_nxt;
	logic [FW-1:0]                 fail_base;
	logic [FW-1:0]                 fail_nxt;
	logic [psufd_pkg::CLS_W-1:0]   cls;
	logic [psufd_pkg::CLS_W-1:0]   cls_nxt;
	logic [NF-1:0]                 act;
	logic [NF-1:0]                 trk_en;
	logic [NF-1:0]                 flags;
	logic                          rise;
	logic                          polled;
	logic                          report;
	logic                          clear_req;
	psufd_pkg::result_t            res_nxt;

	function automatic logic [CW-1:0] limit_of(input int idx);
		return (idx == psufd_pkg::F_PGOOD) ? LIM_PGOOD : LIM_FAULT;
	endfunction

	// ---------------- APB ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_comb begin
		case (paddr[3:2])
			psufd_pkg::REG_MFR_DECODE: prdata = {{(psufd_pkg::APB_DW-1){1'b0}},
				mfr_decode_enable_q};
			psufd_pkg::REG_VIN_MIN: prdata = {{(psufd_pkg::APB_DW-psufd_pkg::MV_W){1'b0}},
				vin_min_mv_q};
			psufd_pkg::REG_VIN_LOW: prdata = {{(psufd_pkg::APB_DW-psufd_pkg::MV_W){1'b0}},
				vin_low_line_mv_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mfr_decode_enable_q <= 1'b0;
			vin_min_mv_q        <= psufd_pkg::VIN_MIN_RST;
			vin_low_line_mv_q   <= psufd_pkg::VIN_LOW_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				psufd_pkg::REG_MFR_DECODE: mfr_decode_enable_q <= pwdata[0];
				psufd_pkg::REG_VIN_MIN:    vin_min_mv_q <= pwdata[psufd_pkg::MV_W-1:0];
				psufd_pkg::REG_VIN_LOW:    vin_low_line_mv_q <= pwdata[psufd_pkg::MV_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- handshake ----------------
	assign advance       = valid_s1 & (~valid_s2 | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | advance;
	assign take_in       = s_axis_tvalid & s_axis_tready;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(psufd_pkg::OUT_TDATA_W-$bits(psufd_pkg::result_t)){1'b0}},
		res_s2};

	// ---------------- poll update ----------------
	always_comb begin
		rise      = poll_s1.present & ~last_present_q;
		polled    = poll_s1.present & poll_s1.status_read_ok;
		cnt_base  = rise ? '0 : cnt_q;
		fail_base = rise ? '0 : fail_q;
		clear_req = rise;
		report    = 1'b0;

		act = '0;
		act[psufd_pkg::F_CML]     = poll_s1.sts_word[psufd_pkg::SWB_CML];
		act[psufd_pkg::F_INPUT]   = poll_s1.sts_word[psufd_pkg::SWB_INPUT];
		act[psufd_pkg::F_VOUT_OV] = poll_s1.sts_word[psufd_pkg::SWB_VOUT_OV];
		act[psufd_pkg::F_IOUT_OC] = poll_s1.sts_word[psufd_pkg::SWB_IOUT_OC];
		act[psufd_pkg::F_VOUT_UV] = poll_s1.sts_word[psufd_pkg::SWB_VOUT] &
			~poll_s1.sts_word[psufd_pkg::SWB_VOUT_OV];
		act[psufd_pkg::F_FAN]     = poll_s1.sts_word[psufd_pkg::SWB_FANS];
		act[psufd_pkg::F_TEMP]    = poll_s1.sts_word[psufd_pkg::SWB_TEMP];
		act[psufd_pkg::F_PGOOD]   = poll_s1.sts_word[psufd_pkg::SWB_PGOOD_NEG] |
			poll_s1.sts_word[psufd_pkg::SWB_UNIT_OFF];
		act[psufd_pkg::F_MFR]     = poll_s1.sts_word[psufd_pkg::SWB_MFR];
		act[psufd_pkg::F_VIN_UV]  = poll_s1.sts_word[psufd_pkg::SWB_VIN_UV];
		act[psufd_pkg::F_KILL]    = poll_s1.vendor_sts[psufd_pkg::MFRB_KILL];
		act[psufd_pkg::F_12VCS]   = poll_s1.vendor_sts[psufd_pkg::MFRB_12VCS];
		act[psufd_pkg::F_CS12V]   = poll_s1.vendor_sts[psufd_pkg::MFRB_CS12V];

		// vendor counters hold unless the MFR bit is up and decoding is on; a zero status word still clears them
		trk_en = '1;
		trk_en[psufd_pkg::F_KILL]  = poll_s1.sts_word[psufd_pkg::SWB_MFR] &
			mfr_decode_enable_q;
		trk_en[psufd_pkg::F_12VCS] = trk_en[psufd_pkg::F_KILL];
		trk_en[psufd_pkg::F_CS12V] = trk_en[psufd_pkg::F_KILL];

		for (int i = 0; i < NF; i++) begin
			if (!polled || (poll_s1.sts_word != '0 && !trk_en[i]))
				cnt_nxt[i] = cnt_base[i];
			else if (poll_s1.sts_word == '0 || !act[i])
				cnt_nxt[i] = '0;
			else if (cnt_base[i] < limit_of(i))
				cnt_nxt[i] = cnt_base[i] + CW'(1);
			else
				cnt_nxt[i] = cnt_base[i];
		end

		fail_nxt = fail_base;
		if (poll_s1.present) begin
			if (!poll_s1.status_read_ok) begin
				if (fail_base != FAIL_SAT) begin
					fail_nxt = fail_base + FW'(1);
					report   = (fail_nxt == LIM_LOG);
				end
			end else begin
				fail_nxt = '0;
			end
		end

		if (!poll_s1.vin_read_ok || poll_s1.vin_millivolts < vin_min_mv_q)
			cls = psufd_pkg::CLS_NONE;
		else if (poll_s1.vin_millivolts < vin_low_line_mv_q)
			cls = psufd_pkg::CLS_LOW;
		else
			cls = psufd_pkg::CLS_HIGH;

		cls_nxt = last_cls_q;
		if (polled) begin
			cls_nxt = cls;
			// recovery from no input or a pending VIN UV fault
			if (cls != psufd_pkg::CLS_NONE &&
			    (last_cls_q == psufd_pkg::CLS_NONE ||
			     cnt_nxt[psufd_pkg::F_VIN_UV] != '0)) begin
				cnt_nxt[psufd_pkg::F_VIN_UV] = '0;
				clear_req = 1'b1;
			end
		end

		for (int i = 0; i < NF; i++)
			flags[i] = (cnt_nxt[i] >= limit_of(i));

		res_nxt.fault_flags          = flags;
		res_nxt.available            = poll_s1.present & ~flags[psufd_pkg::F_INPUT] &
			~flags[psufd_pkg::F_VIN_UV] & ~flags[psufd_pkg::F_KILL] &
			~flags[psufd_pkg::F_IOUT_OC];
		res_nxt.voltage_class        = cls_nxt;
		res_nxt.read_fail_report     = report;
		res_nxt.vin_uv_clear_request = clear_req;
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			cnt_q          <= '0;
			fail_q         <= '0;
			last_present_q <= 1'b0;
			last_cls_q     <= psufd_pkg::CLS_NONE;
		end else begin
			if (take_in)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;

			if (advance)
				valid_s2 <= 1'b1;
			else if (m_axis_tready)
				valid_s2 <= 1'b0;

			if (advance) begin
				cnt_q          <= cnt_nxt;
				fail_q         <= fail_nxt;
				last_present_q <= poll_s1.present;
				last_cls_q     <= cls_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			poll_s1.present        <= s_axis_tuser[0];
			poll_s1.status_read_ok <= s_axis_tuser[1];
			poll_s1.vin_read_ok    <= s_axis_tuser[2];
			poll_s1.sts_word       <= s_axis_tdata[15:0];
			poll_s1.vendor_sts     <= s_axis_tdata[23:16];
			poll_s1.vin_millivolts <= s_axis_tdata[42:24];
		end
		if (advance)
			res_s2 <= res_nxt;
	end

`ifndef SYNTHESIS
	// state only moves when a poll goes through
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(cnt_q) && $stable(fail_q) && $stable(last_cls_q))
		else $error("deglitch state changed without a poll");

	// an absent supply is never available and issues no clear request or read-fail report
	a_absent: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !poll_s1.present |=> !res_s2.available &&
			!res_s2.vin_uv_clear_request && !res_s2.read_fail_report)
		else $error("absent supply gave available, report or clear");

	// available implies the input fault is not debounced
	a_avail: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.available |-> !res_s2.fault_flags[psufd_pkg::F_INPUT])
		else $error("available with input fault flagged");

	// a stalled result is not overwritten
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !m_axis_tready |-> !advance)
		else $error("result register overwritten while stalled");
`endif

endmodule
